/* src/lru_pkg.sv */
// Package with shared constants, types and codes for the recency list.
package lru_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 32;
    localparam int POS_BITS = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    localparam logic [2:0] FUNC_INSERT_HEAD = 3'd0;
    localparam logic [2:0] FUNC_INSERT_TAIL = 3'd1;
    localparam logic [2:0] FUNC_POP_TAIL = 3'd2;
    localparam logic [2:0] FUNC_REMOVE = 3'd3;
    localparam logic [2:0] FUNC_FIND = 3'd4;
    localparam logic [2:0] FUNC_REFRESH = 3'd5;

    typedef struct packed {
        logic [2:0] func;
        logic [31:0] key;
    } req_t;

    typedef struct packed {
        logic hit;
        logic rejected;
        logic [31:0] popped_key;
        logic [31:0] tail_key;
        logic [4:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic search;
        logic update;
    } lru_cmd_t;

    typedef struct packed {
        logic search_done;
    } lru_sts_t;

endpackage

/* src/lru_datapath.sv */
// Datapath with the key registers, the search pass and the reorder.
module lru_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  lru_pkg::req_t     req,
    input  lru_pkg::lru_cmd_t cmd,
    output lru_pkg::lru_sts_t sts,
    output lru_pkg::rsp_t     rsp
);
    import lru_pkg::*;

    localparam int HALF = (CAPACITY + 1) / 2;

    logic [KEY_BITS-1:0]   keys_reg [CAPACITY];
    logic [KEY_BITS-1:0]   keys_next [CAPACITY];
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [2:0]            func_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic                  half_reg;
    logic                  found_reg, found_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    rsp_t                  rsp_reg, rsp_next;

    always_comb
    begin
        logic [POS_BITS:0] idx;
        found_next = found_reg;
        pos_next = pos_reg;
        for (int i = 0; i < HALF; i++)
        begin
            idx = half_reg ? (POS_BITS+1)'(i + HALF) : (POS_BITS+1)'(i);
            if (idx < (POS_BITS+1)'(CAPACITY) && !found_next
                && {1'b0, idx} < {1'b0, (POS_BITS+1)'(count_reg)}
                && keys_reg[idx[POS_BITS-1:0]] == key_reg)
            begin
                found_next = 1'b1;
                pos_next = idx[POS_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        logic                  valid_key, full, do_drop, do_head, do_tail;
        logic [COUNT_BITS-1:0] cnt;
        logic [POS_BITS-1:0]   last;
        keys_next = keys_reg;
        count_next = count_reg;
        rsp_next = rsp_reg;
        valid_key = key_reg != '0;
        full = count_reg == COUNT_BITS'(CAPACITY);
        do_drop = 1'b0;
        do_head = 1'b0;
        do_tail = 1'b0;
        last = '0;
        rsp_next.hit = 1'b0;
        rsp_next.rejected = 1'b0;
        rsp_next.popped_key = '0;
        case (func_reg)
            FUNC_INSERT_HEAD, FUNC_INSERT_TAIL:
            begin
                if (valid_key)
                begin
                    rsp_next.hit = found_reg;
                    if (!found_reg && full)
                        rsp_next.rejected = 1'b1;
                    else
                    begin
                        do_drop = found_reg;
                        do_head = func_reg == FUNC_INSERT_HEAD;
                        do_tail = func_reg == FUNC_INSERT_TAIL;
                    end
                end
            end
            FUNC_POP_TAIL:
            begin
                if (count_reg != '0)
                begin
                    rsp_next.hit = 1'b1;
                    last = POS_BITS'(count_reg - 1'b1);
                    rsp_next.popped_key = 32'(keys_reg[last]);
                    count_next = count_reg - 1'b1;
                end
            end
            FUNC_REMOVE:
            begin
                rsp_next.hit = valid_key && found_reg;
                do_drop = valid_key && found_reg;
            end
            FUNC_FIND:
                rsp_next.hit = valid_key && found_reg;
            FUNC_REFRESH:
            begin
                rsp_next.hit = valid_key && found_reg;
                do_drop = valid_key && found_reg && pos_reg != '0;
                do_head = do_drop;
            end
            default:
                rsp_next.hit = 1'b0;
        endcase
        cnt = count_next;
        if (do_drop)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
                if (POS_BITS'(i) >= pos_reg)
                    keys_next[i] = keys_reg[i+1];
            cnt = cnt - 1'b1;
        end
        if (do_head)
        begin
            for (int i = CAPACITY - 1; i > 0; i--)
                keys_next[i] = do_drop && POS_BITS'(i) > pos_reg ? keys_reg[i]
                             : (do_drop && POS_BITS'(i) <= pos_reg ? keys_reg[i-1]
                             : keys_reg[i-1]);
            keys_next[0] = key_reg;
            cnt = cnt + 1'b1;
        end
        else if (do_tail)
        begin
            keys_next[POS_BITS'(cnt)] = key_reg;
            cnt = cnt + 1'b1;
        end
        count_next = cnt;
        rsp_next.entry_count = 5'(cnt);
        rsp_next.tail_key = cnt == '0 ? '0
            : 32'(keys_next[POS_BITS'(cnt - 1'b1)]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.update)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= req.func;
            key_reg <= KEY_BITS'(req.key);
            half_reg <= 1'b0;
            found_reg <= 1'b0;
            pos_reg <= '0;
        end
        else if (cmd.search)
        begin
            half_reg <= 1'b1;
            found_reg <= found_next;
            pos_reg <= pos_next;
        end
        if (cmd.update)
        begin
            keys_reg <= keys_next;
            rsp_reg <= rsp_next;
        end
    end

    assign sts.search_done = half_reg;
    assign rsp = rsp_reg;

endmodule

/* src/lru_ctrl.sv */
// Controller state machine that sequences load, search and update.
module lru_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  lru_pkg::lru_sts_t sts,
    output lru_pkg::lru_cmd_t cmd
);
    import lru_pkg::*;

    typedef enum logic [1:0] {IDLE, SEARCH, UPDATE} state_t;

    state_t state_reg;
    logic   valid_reg;

    assign in_ready = state_reg == IDLE && !(valid_reg && !out_ready);
    assign out_valid = valid_reg;
    assign cmd.load = in_valid && in_ready;
    assign cmd.search = state_reg == SEARCH;
    assign cmd.update = state_reg == UPDATE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == UPDATE)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
            case (state_reg)
                IDLE:
                    if (cmd.load)
                        state_reg <= SEARCH;
                SEARCH:
                    if (sts.search_done)
                        state_reg <= UPDATE;
                UPDATE:
                    state_reg <= IDLE;
                default:
                    state_reg <= IDLE;
            endcase
        end
    end

endmodule

/* src/lru_recency_list.sv */
// Top level of the recency-ordered key list.
// out_valid rises after the two search halves and the update state that follow the accepting edge.
// A new request is accepted only back in IDLE, once the two-pass key search and the update are done.
// While a result waits, the next request may be accepted once it is taken.
// Reset clears the entry count and the handshake state; key storage is not cleared.
module lru_recency_list (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  lru_pkg::req_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output lru_pkg::rsp_t  out_data
);
    import lru_pkg::*;

    lru_cmd_t cmd;
    lru_sts_t sts;

    lru_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
    );

    lru_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .req(in_data), .cmd(cmd), .sts(sts), .rsp(out_data)
    );

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.entry_count <= 5'(CAPACITY))
        else $error("entry count above capacity");

    a_empty_tail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.entry_count == '0 |-> out_data.tail_key == '0)
        else $error("empty list reports a tail key");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.rejected |-> out_data.entry_count == 5'(CAPACITY))
        else $error("rejection without a full list");

endmodule
